/* rtl/core/cws_pkg.sv */
// Shared constants, types and the saturating clamp for the column weighted sum block.
`default_nettype none

package cws_pkg;

    // Fixed-point format
    localparam int FRAC_BITS   = 16;
    localparam int IN_W        = 32;
    localparam int OUT_W       = 48;
    localparam int PROD_W      = 2 * IN_W;
    localparam int VAL_W       = OUT_W + IN_W;
    localparam int CNT_W       = $clog2(VAL_W + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W   = 2;

    // Reset value of the coefficient: 1.0
    localparam logic [IN_W-1:0] COEF_RESET = {{(IN_W-1){1'b0}}, 1'b1} << FRAC_BITS;

    // Signed output bounds, and the same bounds as wide magnitudes
    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
    localparam logic [VAL_W-1:0] POS_LIMIT = {{(VAL_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] NEG_LIMIT = {{(VAL_W-OUT_W){1'b0}}, 1'b1, {(OUT_W-1){1'b0}}};

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEFFICIENT       = 2'd0,
        CFG_INCLUDE_VOLUME    = 2'd1,
        CFG_DIVIDE_BY_DENSITY = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic signed [IN_W-1:0] coefficient;
        logic                   include_volume;
        logic                   divide_by_density;
    } t_cfg;

    // How the back end forms a cell term
    typedef enum logic [2:0] {
        KIND_PASS,
        KIND_DIV,
        KIND_MUL_SHIFT,
        KIND_MUL_DIV,
        KIND_ZERO
    } t_kind;

    typedef struct packed {
        logic            neg;
        logic [IN_W-1:0] mag;
        logic [IN_W-1:0] volume;
        logic [IN_W-1:0] density;
        logic [IN_W-1:0] surface;
        logic            last;
        t_kind           kind;
    } t_cell;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CMUL,
        ST_DIV,
        ST_TERM,
        ST_ACC,
        ST_RMUL_LO,
        ST_RMUL_HI,
        ST_RPREP,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic                    sat;
        logic signed [OUT_W-1:0] value;
    } t_clamp;

    // Clamp a sign and magnitude to the signed output range
    function automatic t_clamp f_clamp(input logic neg, input logic [VAL_W-1:0] mag);
        t_clamp r;
        r.sat = 1'b0;
        if (neg) begin
            if (mag > NEG_LIMIT) begin
                r.sat   = 1'b1;
                r.value = OUT_MIN;
            end else begin
                r.value = ~mag[OUT_W-1:0] + 1'b1;
            end
        end else begin
            if (mag > POS_LIMIT) begin
                r.sat   = 1'b1;
                r.value = OUT_MAX;
            end else begin
                r.value = mag[OUT_W-1:0];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/cws_front.sv */
// Front end: takes cell transfers, splits sign and magnitude and classifies the term.
`default_nettype none

module cws_front (
    input  wire logic                          i_in_valid,
    input  wire logic signed [cws_pkg::IN_W-1:0] i_cell_value,
    input  wire logic [cws_pkg::IN_W-1:0]      i_cell_volume,
    input  wire logic [cws_pkg::IN_W-1:0]      i_molar_density,
    input  wire logic [cws_pkg::IN_W-1:0]      i_surface_volume,
    input  wire logic                          i_last_in_column,
    input  wire cws_pkg::t_cfg                 i_cfg,
    input  wire logic                          i_queue_full,
    output logic                               o_in_stall,
    output logic                               o_push,
    output cws_pkg::t_cell                     o_cell
);

    logic                     w_neg;
    logic [cws_pkg::IN_W-1:0] w_mag;
    logic                     w_dens_zero;
    cws_pkg::t_kind           w_kind;

    // Hold the sender while the queue has no room
    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid & ~i_queue_full;

    // Split the value into sign and magnitude
    assign w_neg = i_cell_value[cws_pkg::IN_W-1];
    assign w_mag = w_neg ? (~unsigned'(i_cell_value) + 1'b1) : unsigned'(i_cell_value);

    // Pick the term path from the configuration and the density
    assign w_dens_zero = (i_molar_density == '0);

    always_comb begin
        if (i_cfg.include_volume) begin
            if (i_cfg.divide_by_density) begin
                w_kind = w_dens_zero ? cws_pkg::KIND_ZERO : cws_pkg::KIND_MUL_DIV;
            end else begin
                w_kind = cws_pkg::KIND_MUL_SHIFT;
            end
        end else if (i_cfg.divide_by_density) begin
            w_kind = w_dens_zero ? cws_pkg::KIND_ZERO : cws_pkg::KIND_DIV;
        end else begin
            w_kind = cws_pkg::KIND_PASS;
        end
    end

    // Pack the classified cell
    always_comb begin
        o_cell.neg     = w_neg;
        o_cell.mag     = w_mag;
        o_cell.volume  = i_cell_volume;
        o_cell.density = i_molar_density;
        o_cell.surface = i_surface_volume;
        o_cell.last    = i_last_in_column;
        o_cell.kind    = w_kind;
    end

endmodule

`default_nettype wire

/* rtl/core/cws_queue.sv */
// Short queue of classified cells between the front end and the back end.
`default_nettype none

module cws_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire cws_pkg::t_cell i_cell,
    input  wire logic           i_pop,
    output cws_pkg::t_cell      o_cell,
    output logic                o_empty,
    output logic                o_full
);

    cws_pkg::t_cell             r_mem [cws_pkg::QUEUE_DEPTH];
    logic [cws_pkg::QPTR_W-1:0] r_wptr;
    logic [cws_pkg::QPTR_W-1:0] r_rptr;
    logic [cws_pkg::QCNT_W-1:0] r_count;
    logic [cws_pkg::QPTR_W-1:0] n_wptr;
    logic [cws_pkg::QPTR_W-1:0] n_rptr;
    logic [cws_pkg::QCNT_W-1:0] n_count;
    logic                       w_do_push;
    logic                       w_do_pop;

    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == cws_pkg::QCNT_W'(cws_pkg::QUEUE_DEPTH));
    assign w_do_push = i_push & ~o_full;
    assign w_do_pop  = i_pop & ~o_empty;
    assign o_cell    = r_mem[r_rptr];

    // Advance pointers and the fill count
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_do_push) begin
            n_wptr = (r_wptr == cws_pkg::QPTR_W'(cws_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rptr = (r_rptr == cws_pkg::QPTR_W'(cws_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Store the pushed cell
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wptr] <= i_cell;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/cws_back.sv */
// Back end: forms each term, accumulates the column and produces the scaled result.
`default_nettype none

module cws_back (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire cws_pkg::t_cfg           i_cfg,
    input  wire cws_pkg::t_cell          i_cell,
    input  wire logic                    i_empty,
    input  wire logic                    i_out_stall,
    output logic                         o_pop,
    output logic                         o_out_valid,
    output logic signed [cws_pkg::OUT_W-1:0] o_column_result,
    output logic                         o_saturated,
    output logic                         o_divide_error
);

    // Control state
    cws_pkg::t_state                 r_state, n_state;
    logic signed [cws_pkg::OUT_W-1:0] r_acc, n_acc;
    logic                            r_sat, n_sat;
    logic                            r_derr, n_derr;
    logic                            r_out_valid, n_out_valid;

    // Working payload
    logic                            r_neg, n_neg;
    logic [cws_pkg::IN_W-1:0]        r_mag, n_mag;
    logic [cws_pkg::IN_W-1:0]        r_vol, n_vol;
    logic [cws_pkg::IN_W-1:0]        r_surf, n_surf;
    logic                            r_last, n_last;
    cws_pkg::t_kind                  r_kind, n_kind;
    logic [cws_pkg::VAL_W-1:0]       r_val, n_val;
    logic [cws_pkg::IN_W-1:0]        r_rem, n_rem;
    logic [cws_pkg::IN_W-1:0]        r_dvs, n_dvs;
    logic [cws_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic                            r_res, n_res;
    logic signed [cws_pkg::OUT_W-1:0] r_term, n_term;
    logic signed [cws_pkg::OUT_W-1:0] r_out_result, n_out_result;
    logic                            r_out_sat, n_out_sat;
    logic                            r_out_derr, n_out_derr;

    // Datapath
    logic [cws_pkg::IN_W-1:0]        w_mul_a;
    logic [cws_pkg::IN_W-1:0]        w_mul_b;
    logic [cws_pkg::PROD_W-1:0]      w_mul_p;
    logic [cws_pkg::IN_W:0]          w_rem_sh;
    logic [cws_pkg::IN_W:0]          w_rem_sub;
    logic                            w_qbit;
    logic [cws_pkg::OUT_W-1:0]       w_acc_mag;
    logic [cws_pkg::IN_W-1:0]        w_coef_mag;
    logic                            w_rneg;
    logic signed [cws_pkg::OUT_W:0]  w_sum;
    logic                            w_sum_ovf;
    cws_pkg::t_clamp                 w_term_clamp;
    cws_pkg::t_clamp                 w_res_clamp;
    logic                            w_out_free;

    assign o_out_valid     = r_out_valid;
    assign o_column_result = r_out_result;
    assign o_saturated     = r_out_sat;
    assign o_divide_error  = r_out_derr;

    // Magnitudes for the result product
    assign w_acc_mag  = r_acc[cws_pkg::OUT_W-1] ? (~unsigned'(r_acc) + 1'b1) : unsigned'(r_acc);
    assign w_coef_mag = i_cfg.coefficient[cws_pkg::IN_W-1]
                      ? (~unsigned'(i_cfg.coefficient) + 1'b1) : unsigned'(i_cfg.coefficient);
    assign w_rneg     = i_cfg.coefficient[cws_pkg::IN_W-1] ^ r_acc[cws_pkg::OUT_W-1];

    // Shared multiplier, operands chosen by state
    always_comb begin
        case (r_state)
            cws_pkg::ST_RMUL_LO: begin
                w_mul_a = w_acc_mag[cws_pkg::IN_W-1:0];
                w_mul_b = w_coef_mag;
            end
            cws_pkg::ST_RMUL_HI: begin
                w_mul_a = cws_pkg::IN_W'(w_acc_mag[cws_pkg::OUT_W-1:cws_pkg::IN_W]);
                w_mul_b = w_coef_mag;
            end
            default: begin
                w_mul_a = r_mag;
                w_mul_b = r_vol;
            end
        endcase
    end
    assign w_mul_p = w_mul_a * w_mul_b;

    // One restoring divide step per cycle
    assign w_rem_sh  = {r_rem, r_val[cws_pkg::VAL_W-1]};
    assign w_qbit    = (w_rem_sh >= {1'b0, r_dvs});
    assign w_rem_sub = w_rem_sh - {1'b0, r_dvs};

    // Saturating accumulate
    assign w_sum     = {r_acc[cws_pkg::OUT_W-1], r_acc} + {r_term[cws_pkg::OUT_W-1], r_term};
    assign w_sum_ovf = (w_sum[cws_pkg::OUT_W] != w_sum[cws_pkg::OUT_W-1]);

    assign w_term_clamp = cws_pkg::f_clamp(r_neg, r_val);
    assign w_res_clamp  = cws_pkg::f_clamp(w_rneg, r_val);
    assign w_out_free   = ~r_out_valid | ~i_out_stall;

    // Sequencer: next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_acc        = r_acc;
        n_sat        = r_sat;
        n_derr       = r_derr;
        n_out_valid  = r_out_valid & i_out_stall;
        n_neg        = r_neg;
        n_mag        = r_mag;
        n_vol        = r_vol;
        n_surf       = r_surf;
        n_last       = r_last;
        n_kind       = r_kind;
        n_val        = r_val;
        n_rem        = r_rem;
        n_dvs        = r_dvs;
        n_cnt        = r_cnt;
        n_res        = r_res;
        n_term       = r_term;
        n_out_result = r_out_result;
        n_out_sat    = r_out_sat;
        n_out_derr   = r_out_derr;
        o_pop        = 1'b0;

        case (r_state)
            cws_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    o_pop  = 1'b1;
                    n_neg  = i_cell.neg;
                    n_mag  = i_cell.mag;
                    n_vol  = i_cell.volume;
                    n_surf = i_cell.surface;
                    n_last = i_cell.last;
                    n_kind = i_cell.kind;
                    n_dvs  = i_cell.density;
                    n_rem  = '0;
                    n_res  = 1'b0;
                    case (i_cell.kind)
                        cws_pkg::KIND_PASS: begin
                            n_val   = cws_pkg::VAL_W'(i_cell.mag);
                            n_state = cws_pkg::ST_TERM;
                        end
                        cws_pkg::KIND_ZERO: begin
                            n_val   = '0;
                            n_derr  = 1'b1;
                            n_state = cws_pkg::ST_TERM;
                        end
                        cws_pkg::KIND_DIV: begin
                            // magnitude times 1.0, left-aligned in the dividend register
                            n_val   = cws_pkg::VAL_W'(i_cell.mag)
                                      << (cws_pkg::VAL_W - cws_pkg::IN_W);
                            n_cnt   = cws_pkg::CNT_W'(cws_pkg::IN_W + cws_pkg::FRAC_BITS);
                            n_state = cws_pkg::ST_DIV;
                        end
                        default: begin
                            n_state = cws_pkg::ST_CMUL;
                        end
                    endcase
                end
            end
            cws_pkg::ST_CMUL: begin
                if (r_kind == cws_pkg::KIND_MUL_DIV) begin
                    n_val   = cws_pkg::VAL_W'(w_mul_p) << (cws_pkg::VAL_W - cws_pkg::PROD_W);
                    n_cnt   = cws_pkg::CNT_W'(cws_pkg::PROD_W);
                    n_state = cws_pkg::ST_DIV;
                end else begin
                    n_val   = cws_pkg::VAL_W'(w_mul_p >> cws_pkg::FRAC_BITS);
                    n_state = cws_pkg::ST_TERM;
                end
            end
            cws_pkg::ST_DIV: begin
                n_rem = w_qbit ? w_rem_sub[cws_pkg::IN_W-1:0] : w_rem_sh[cws_pkg::IN_W-1:0];
                n_val = {r_val[cws_pkg::VAL_W-2:0], w_qbit};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == cws_pkg::CNT_W'(1)) begin
                    n_state = r_res ? cws_pkg::ST_OUT : cws_pkg::ST_TERM;
                end
            end
            cws_pkg::ST_TERM: begin
                n_term  = w_term_clamp.value;
                n_sat   = r_sat | w_term_clamp.sat;
                n_state = cws_pkg::ST_ACC;
            end
            cws_pkg::ST_ACC: begin
                if (w_sum_ovf) begin
                    n_acc = w_sum[cws_pkg::OUT_W] ? cws_pkg::OUT_MIN : cws_pkg::OUT_MAX;
                    n_sat = 1'b1;
                end else begin
                    n_acc = w_sum[cws_pkg::OUT_W-1:0];
                end
                n_state = r_last ? cws_pkg::ST_RMUL_LO : cws_pkg::ST_IDLE;
            end
            cws_pkg::ST_RMUL_LO: begin
                n_val   = cws_pkg::VAL_W'(w_mul_p);
                n_state = cws_pkg::ST_RMUL_HI;
            end
            cws_pkg::ST_RMUL_HI: begin
                n_val   = r_val + (cws_pkg::VAL_W'(w_mul_p) << cws_pkg::IN_W);
                n_state = cws_pkg::ST_RPREP;
            end
            cws_pkg::ST_RPREP: begin
                if (i_cfg.include_volume) begin
                    if (r_surf == '0) begin
                        n_val   = '0;
                        n_derr  = 1'b1;
                        n_state = cws_pkg::ST_OUT;
                    end else begin
                        n_rem   = '0;
                        n_dvs   = r_surf;
                        n_cnt   = cws_pkg::CNT_W'(cws_pkg::VAL_W);
                        n_res   = 1'b1;
                        n_state = cws_pkg::ST_DIV;
                    end
                end else begin
                    n_val   = r_val >> cws_pkg::FRAC_BITS;
                    n_state = cws_pkg::ST_OUT;
                end
            end
            cws_pkg::ST_OUT: begin
                // hand over the result and start the next column clean
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_result = w_res_clamp.value;
                    n_out_sat    = r_sat | w_res_clamp.sat;
                    n_out_derr   = r_derr;
                    n_acc        = '0;
                    n_sat        = 1'b0;
                    n_derr       = 1'b0;
                    n_state      = cws_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cws_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cws_pkg::ST_IDLE;
            r_acc       <= '0;
            r_sat       <= 1'b0;
            r_derr      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_sat       <= n_sat;
            r_derr      <= n_derr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg        <= n_neg;
        r_mag        <= n_mag;
        r_vol        <= n_vol;
        r_surf       <= n_surf;
        r_last       <= n_last;
        r_kind       <= n_kind;
        r_val        <= n_val;
        r_rem        <= n_rem;
        r_dvs        <= n_dvs;
        r_cnt        <= n_cnt;
        r_res        <= n_res;
        r_term       <= n_term;
        r_out_result <= n_out_result;
        r_out_sat    <= n_out_sat;
        r_out_derr   <= n_out_derr;
    end

endmodule

`default_nettype wire

/* rtl/core/column_weighted_sum.sv */
// Column weighted sum: cells in, one saturated Q32.16 result per column out.
// In the back end each cell passes the term and accumulate states, after a multiply for volume
// and a density division (one quotient bit a cycle) where those options are on.
// The last cell of a column then forms the result product, plus a surface volume division with volume on.
// A two-entry queue lets cells enter while the back end works; the result waits in an output register.
// Synchronous active-low reset clears the queue, accumulator, flags and output valid,
// and loads the configuration defaults (coefficient 1.0, both weighting options on).
`default_nettype none

module column_weighted_sum (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic signed [cws_pkg::IN_W-1:0]    i_cell_value,
    input  wire logic [cws_pkg::IN_W-1:0]           i_cell_volume,
    input  wire logic [cws_pkg::IN_W-1:0]           i_molar_density,
    input  wire logic [cws_pkg::IN_W-1:0]           i_surface_volume,
    input  wire logic                               i_last_in_column,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic signed [cws_pkg::OUT_W-1:0]        o_column_result,
    output logic                                    o_saturated,
    output logic                                    o_divide_error,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [cws_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [cws_pkg::IN_W-1:0]           i_cfg_data
);

    logic signed [cws_pkg::IN_W-1:0] r_coef;
    logic                            r_inc_vol;
    logic                            r_div_dens;
    cws_pkg::t_cfg                   w_cfg;
    logic                            w_push;
    logic                            w_pop;
    logic                            w_empty;
    logic                            w_full;
    cws_pkg::t_cell                  w_cell_in;
    cws_pkg::t_cell                  w_cell_head;

    // Configuration registers: always ready for a transfer
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef     <= cws_pkg::COEF_RESET;
            r_inc_vol  <= 1'b1;
            r_div_dens <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (cws_pkg::t_cfg_index'(i_cfg_index))
                cws_pkg::CFG_COEFFICIENT:       r_coef     <= i_cfg_data;
                cws_pkg::CFG_INCLUDE_VOLUME:    r_inc_vol  <= i_cfg_data[0];
                cws_pkg::CFG_DIVIDE_BY_DENSITY: r_div_dens <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_cfg.coefficient       = r_coef;
        w_cfg.include_volume    = r_inc_vol;
        w_cfg.divide_by_density = r_div_dens;
    end

    cws_front u_front (
        .i_in_valid       (i_in_valid),
        .i_cell_value     (i_cell_value),
        .i_cell_volume    (i_cell_volume),
        .i_molar_density  (i_molar_density),
        .i_surface_volume (i_surface_volume),
        .i_last_in_column (i_last_in_column),
        .i_cfg            (w_cfg),
        .i_queue_full     (w_full),
        .o_in_stall       (o_in_stall),
        .o_push           (w_push),
        .o_cell           (w_cell_in)
    );

    cws_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cell  (w_cell_in),
        .i_pop   (w_pop),
        .o_cell  (w_cell_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    cws_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_cell          (w_cell_head),
        .i_empty         (w_empty),
        .i_out_stall     (i_out_stall),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .o_column_result (o_column_result),
        .o_saturated     (o_saturated),
        .o_divide_error  (o_divide_error)
    );

endmodule

`default_nettype wire

/* rtl/core/cws_checker.sv */
// Port-level checks for the column weighted sum, bound to the top level.
`default_nettype none

module cws_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          o_in_stall,
    input  wire logic signed [cws_pkg::IN_W-1:0] i_cell_value,
    input  wire logic [cws_pkg::IN_W-1:0]      i_cell_volume,
    input  wire logic [cws_pkg::IN_W-1:0]      i_molar_density,
    input  wire logic [cws_pkg::IN_W-1:0]      i_surface_volume,
    input  wire logic                          i_last_in_column,
    input  wire logic                          o_out_valid,
    input  wire logic                          i_out_stall,
    input  wire logic signed [cws_pkg::OUT_W-1:0] o_column_result,
    input  wire logic                          o_saturated,
    input  wire logic                          o_divide_error
);

    // Reset drops any pending result
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // Reset empties the queue, so cells are taken at once
    a_reset_clears_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled right after reset");

    // A stalled cell holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_cell_value)
            && $stable(i_cell_volume) && $stable(i_molar_density)
            && $stable(i_surface_volume) && $stable(i_last_in_column))
        else $error("stalled cell changed");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_column_result)
            && $stable(o_saturated) && $stable(o_divide_error))
        else $error("stalled result changed");

endmodule

bind column_weighted_sum cws_checker u_cws_checker (.*);

`default_nettype wire
